>>> rtl/rmf_pkg.sv
package rmf_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MEDIAN_BITS = SAMPLE_BITS + 1;
  localparam int unsigned COUNT_BITS  = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [MEDIAN_BITS-1:0] median_t;

  // Handed from each cell to its right-hand neighbor.
  typedef struct packed {
    sample_t value;  // sorted value after removal
    logic    gt;     // value is held and greater than the new sample
    logic    found;  // oldest value matched at or left of this cell
    sample_t ring;   // arrival-order sample shifting right
  } link_t;

endpackage

>>> rtl/running_median_filter.sv
// Running median over the last WINDOW signed samples.
// Input channel: in_valid_i / in_ready_o carry sample_i, one transaction per
// sample. Output channel: out_valid_o / out_ready_i carry median_twice_o
// (twice the median, exact for even counts) and held_count_o (samples held,
// taken modulo 8), one transaction per input transaction, in order.
// A row of WINDOW cells holds both the arrival-order ring and the sorted
// copy; in the cycle a sample is accepted every cell removes the oldest value
// (once the window is full) and inserts the new one in place. Once the output
// register is free, the two middle cells are selected and added into it.
// Throughput: one sample per cycle while out_ready_i is high.
// When the receiver stalls, one result waits in the output register and one
// more in the cell row; in_ready_o then drops until out_ready_i returns.
// Reset empties the window (fill count zero) and drops any pending result;
// no clearing pass is needed.
module running_median_filter #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [rmf_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [rmf_pkg::MEDIAN_BITS-1:0] median_twice_o,
  output logic [rmf_pkg::COUNT_BITS-1:0]        held_count_o
);
  import rmf_pkg::*;

  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam logic [CW-1:0] Full = CW'(WINDOW);

  logic [CW-1:0] cnt_q, cnt_d, cnt_rm, lo_idx, hi_idx;
  logic          pend_q, out_valid_q;
  logic          in_fire, capture, full;
  median_t       median_q, median_d;
  logic [COUNT_BITS-1:0] held_q;

  link_t   links [WINDOW+1];
  sample_t vals  [WINDOW+1];
  sample_t los   [WINDOW];
  sample_t his   [WINDOW];
  sample_t lo_or, hi_or;

  assign full    = (cnt_q == Full);
  assign cnt_rm  = full ? CW'(WINDOW - 1) : cnt_q;
  assign cnt_d   = cnt_rm + CW'(1);
  assign capture = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || capture;
  assign in_fire = in_valid_i && in_ready_o;

  assign lo_idx = (cnt_q - CW'(1)) >> 1;
  assign hi_idx = cnt_q >> 1;

  assign links[0]    = '{value: '0, gt: 1'b0, found: 1'b0, ring: sample_i};
  assign vals[WINDOW] = '0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    rmf_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .en_i       (in_fire),
      .sample_i   (sample_i),
      .oldest_i   (links[WINDOW].ring),
      .full_i     (full),
      .cnt_rm_i   (cnt_rm),
      .left_i     (links[i]),
      .right_val_i(vals[i+1]),
      .lo_sel_i   (lo_idx == CW'(i)),
      .hi_sel_i   (hi_idx == CW'(i)),
      .right_o    (links[i+1]),
      .val_o      (vals[i]),
      .lo_o       (los[i]),
      .hi_o       (his[i])
    );
  end

  always_comb begin
    lo_or = '0;
    hi_or = '0;
    for (int i = 0; i < WINDOW; i++) begin
      lo_or = lo_or | los[i];
      hi_or = hi_or | his[i];
    end
    median_d = MEDIAN_BITS'(lo_or) + MEDIAN_BITS'(hi_or);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_q <= cnt_d;
      end
      if (in_fire) begin
        pend_q <= 1'b1;
      end else if (capture) begin
        pend_q <= 1'b0;
      end
      if (capture) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      median_q <= median_d;
      held_q   <= COUNT_BITS'(cnt_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_twice_o = median_q;
  assign held_count_o   = held_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("fill count beyond window");

  a_fire_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> pend_q)
    else $error("accepted sample not pending");

  a_pend_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> cnt_q != '0)
    else $error("pending result with empty window");

  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> out_valid_q)
    else $error("captured result not presented");

endmodule

>>> rtl/rmf_cell.sv
module rmf_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 3
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  rmf_pkg::sample_t sample_i,
  input  rmf_pkg::sample_t oldest_i,
  input  logic             full_i,
  input  logic [CW-1:0]    cnt_rm_i,
  input  rmf_pkg::link_t   left_i,
  input  rmf_pkg::sample_t right_val_i,
  input  logic             lo_sel_i,
  input  logic             hi_sel_i,
  output rmf_pkg::link_t   right_o,
  output rmf_pkg::sample_t val_o,
  output rmf_pkg::sample_t lo_o,
  output rmf_pkg::sample_t hi_o
);
  import rmf_pkg::*;

  localparam logic [CW-1:0] Pos = CW'(IDX);

  sample_t sorted_q, sorted_d;
  sample_t ring_q;
  sample_t removed;
  logic    eq, take, gt_v;

  always_comb begin
    eq      = full_i && (sorted_q == oldest_i);
    take    = full_i && (left_i.found || eq);
    removed = take ? right_val_i : sorted_q;
    gt_v    = (Pos < cnt_rm_i) && ($signed(removed) > $signed(sample_i));
    if (left_i.gt) begin
      sorted_d = left_i.value;
    end else if (gt_v || (Pos == cnt_rm_i)) begin
      sorted_d = sample_i;
    end else begin
      sorted_d = removed;
    end
  end

  // payload only; validity is tracked by the fill count
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sorted_q <= sorted_d;
      ring_q   <= left_i.ring;
    end
  end

  assign right_o = '{value: removed, gt: gt_v, found: left_i.found || eq, ring: ring_q};
  assign val_o   = sorted_q;
  assign lo_o    = lo_sel_i ? sorted_q : '0;
  assign hi_o    = hi_sel_i ? sorted_q : '0;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rmf_pkg::*;

  localparam int unsigned WINDOW        = 5;
  localparam int unsigned DIRECTED_ROWS = 20;
  localparam int unsigned PHASE_ITEMS   = 400;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 8;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    median_t median_twice;
    count_t  held_count;
  } median_result_t;

  typedef struct packed {
    sample_t sample;
    logic    typed;
    median_t median_twice;
    count_t  held_count;
  } directed_row_t;

  logic    clk_i;
  logic    rst_ni       = 1'b0;
  logic    in_valid_i   = 1'b0;
  logic    in_ready_o;
  sample_t sample_i     = '0;
  logic    out_valid_o;
  logic    out_ready_i  = 1'b0;
  median_t median_twice_o;
  count_t  held_count_o;

  running_median_filter #(
    .WINDOW(WINDOW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .median_twice_o(median_twice_o),
    .held_count_o  (held_count_o)
  );

  // Extremes, equal samples, window wrap; typed where obvious.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{sample_t'(-32768), 1'b1, median_t'(-65536), count_t'(1)},
    '{sample_t'(32767),  1'b1, median_t'(-1),     count_t'(2)},
    '{sample_t'(0),      1'b1, median_t'(0),      count_t'(3)},
    '{sample_t'(32767),  1'b1, median_t'(32767),  count_t'(4)},
    '{sample_t'(-32768), 1'b1, median_t'(0),      count_t'(5)},
    '{sample_t'(7),      1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(7),      1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(7),      1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(7),      1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(7),      1'b1, median_t'(14),     count_t'(5)},
    '{sample_t'(-1),     1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(1),      1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(-1),     1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(1),      1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(21845),  1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(-21846), 1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(32767),  1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(32767),  1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(-32768), 1'b0, median_t'(0),      count_t'(0)},
    '{sample_t'(0),      1'b0, median_t'(0),      count_t'(0)}
  };

  int             win_ring   [WINDOW];
  int             win_sorted [WINDOW];
  int             win_fill = 0;
  int             win_wp   = 0;
  median_result_t pending_medians [$];
  int unsigned    error_count   = 0;
  int unsigned    cycle_count   = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drop the oldest sample from the sorted copy, insert the new one in order.
  function automatic median_result_t window_insert(input sample_t s);
    int             idx;
    int             pos;
    int             twice;
    median_result_t r;
    if (win_fill == WINDOW) begin
      idx = 0;
      while (idx < win_fill && win_sorted[idx] != win_ring[win_wp]) idx++;
      while (idx + 1 < win_fill) begin
        win_sorted[idx] = win_sorted[idx + 1];
        idx++;
      end
      win_fill--;
    end
    win_ring[win_wp] = int'(s);
    win_wp = (win_wp + 1 == WINDOW) ? 0 : win_wp + 1;
    pos = win_fill;
    while (pos > 0 && win_sorted[pos - 1] > int'(s)) begin
      win_sorted[pos] = win_sorted[pos - 1];
      pos--;
    end
    win_sorted[pos] = int'(s);
    win_fill++;
    if (win_fill % 2 == 1) begin
      twice = 2 * win_sorted[win_fill / 2];
    end else begin
      twice = win_sorted[win_fill / 2 - 1] + win_sorted[win_fill / 2];
    end
    r.median_twice = twice[MEDIAN_BITS-1:0];
    r.held_count   = win_fill[COUNT_BITS-1:0];
    return r;
  endfunction

  function automatic sample_t pick_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return sample_t'($urandom);
    if (sel < 80) return sample_t'(int'($urandom_range(6)) - 3);
    case ($urandom_range(3))
      0: return sample_t'(-32768);
      1: return sample_t'(32767);
      2: return sample_t'(0);
      default: return sample_t'(-1);
    endcase
  endfunction

  task automatic send_sample(input sample_t s, output median_result_t predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = window_insert(s);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_medians.size() == 0) begin
        $display("%0t unexpected transaction: median_twice %0d held_count %0d",
                 $time, median_twice_o, held_count_o);
        error_count++;
      end else begin
        if (median_twice_o !== pending_medians[0].median_twice) begin
          $display("%0t median_twice mismatch: expected %0d actual %0d", $time,
                   pending_medians[0].median_twice, median_twice_o);
          error_count++;
        end
        if (held_count_o !== pending_medians[0].held_count) begin
          $display("%0t held_count mismatch: expected %0d actual %0d", $time,
                   pending_medians[0].held_count, held_count_o);
          error_count++;
        end
        void'(pending_medians.pop_front());
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    median_result_t predicted;
    median_result_t typed_result;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].sample, predicted);
      if (directed_rows[i].typed) begin
        typed_result.median_twice = directed_rows[i].median_twice;
        typed_result.held_count   = directed_rows[i].held_count;
        pending_medians.push_back(typed_result);
      end else begin
        pending_medians.push_back(predicted);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_sample(), predicted);
        pending_medians.push_back(predicted);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rmf_pkg.sv
rtl/rmf_cell.sv
rtl/running_median_filter.sv
bench/testbench.sv
